/* hw/rtl/etm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_pkg
// shared types, widths and sine table constants for the euler matrix builder
// ----------------------------------------------------------------------------
package etm_pkg;

	localparam int ANGLE_W       = 16;
	localparam int SCALE_W       = 24;
	localparam int ORDER_W       = 3;
	localparam int OUT_W         = 32;
	localparam int ROT_W         = 18;          // q1.16 sine and cosine, -1.0 .. +1.0
	localparam int ENT_W         = 20;          // matrix entries inside the product chain
	localparam int QUARTER_TURN  = 16384;       // binary angle units in a quarter turn
	localparam int TRIG_LAT      = 2;           // table read plus sign fold
	localparam int LATENCY       = TRIG_LAT + 4;

	// radians per binary angle unit
	localparam real SIN_STEP = 3.14159265358979323846 / 32768.0;

	// rotation orders
	localparam logic [ORDER_W-1:0] ORD_ZYX = 3'd0;
	localparam logic [ORDER_W-1:0] ORD_ZXY = 3'd1;
	localparam logic [ORDER_W-1:0] ORD_YXZ = 3'd2;
	localparam logic [ORDER_W-1:0] ORD_YZX = 3'd3;
	localparam logic [ORDER_W-1:0] ORD_XYZ = 3'd4;
	localparam logic [ORDER_W-1:0] ORD_XZY = 3'd5;

	typedef logic signed [ENT_W-1:0] mat_t [3][3];

	// rounded q1.16 sine of r units, r in 0 .. QUARTER_TURN
	function automatic logic [ROT_W-2:0] quarter_sine(input int r);
		real v;
		v = $sin(r * SIN_STEP) * 65536.0 + 0.5;
		return (ROT_W-1)'($rtoi(v));
	endfunction

endpackage

/* hw/rtl/etm_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_cordic
// sine and cosine of a 16-bit binary angle rounded to q1.16, read from a
// quarter-wave table with registered read, then folded into the full turn
// ----------------------------------------------------------------------------
module etm_cordic import etm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld_i,
	input  logic [ANGLE_W-1:0]      angle,
	output logic                    vld_o,
	output logic signed [ROT_W-1:0] sin_o,
	output logic signed [ROT_W-1:0] cos_o
);

	localparam int IDX_W = $clog2(QUARTER_TURN + 1);

	logic [ROT_W-2:0]   sine_tbl [0:QUARTER_TURN];
	logic [ANGLE_W-1:0] cos_angle;
	logic [IDX_W-1:0]   sin_idx, cos_idx;
	logic               vld_s1, sin_neg_s1, cos_neg_s1;
	logic [ROT_W-2:0]   sin_mag_s1, cos_mag_s1;

	// first quadrant magnitudes, filled once
	initial begin
		for (int r = 0; r <= QUARTER_TURN; r++) sine_tbl[r] = quarter_sine(r);
	end

	// odd quadrants mirror the residue, cosine is the sine a quarter turn on
	always_comb begin
		cos_angle = angle + ANGLE_W'(QUARTER_TURN);
		sin_idx = angle[ANGLE_W-2] ? IDX_W'(QUARTER_TURN) - {1'b0, angle[ANGLE_W-3:0]}
			: {1'b0, angle[ANGLE_W-3:0]};
		cos_idx = cos_angle[ANGLE_W-2] ? IDX_W'(QUARTER_TURN) - {1'b0, cos_angle[ANGLE_W-3:0]}
			: {1'b0, cos_angle[ANGLE_W-3:0]};
	end

	// control: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	// table read, lower half-turn sign carried alongside
	always_ff @(posedge clk) begin
		sin_mag_s1 <= sine_tbl[sin_idx];
		cos_mag_s1 <= sine_tbl[cos_idx];
		sin_neg_s1 <= angle[ANGLE_W-1];
		cos_neg_s1 <= cos_angle[ANGLE_W-1];
	end

	// fold back into the full turn
	always_ff @(posedge clk) begin
		sin_o <= sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
		cos_o <= cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});
	end

endmodule

/* hw/rtl/etm_matmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_matmul
// registered 3x3 product in q16, each entry floored after the exact sum
// ----------------------------------------------------------------------------
module etm_matmul import etm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_i,
	input  mat_t a,
	input  mat_t b,
	output logic vld_o,
	output mat_t o
);

	logic signed [2*ENT_W-1:0] pr  [3][3][3];
	logic signed [2*ENT_W+1:0] acc [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++)
					pr[i][j][k] = a[i][k] * b[k][j];
				acc[i][j] = (2*ENT_W+2)'(pr[i][j][0]) + (2*ENT_W+2)'(pr[i][j][1])
					+ (2*ENT_W+2)'(pr[i][j][2]);
			end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o <= 1'b0;
		else         vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				o[i][j] <= ENT_W'(acc[i][j] >>> 16);
	end

endmodule

/* hw/rtl/euler_trs_matrix_builder.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle, busy is never raised
// the depth is set by the sine table read and sign fold, the order select, two matrix
// products and the column scale, one register rank each
// reset: arst_n clears every valid bit at once, payload registers are not reset
// ----------------------------------------------------------------------------
// euler_trs_matrix_builder
// builds the scaled 3x3 rotation block from three euler angles, three column
// scales and a rotation order, fully pipelined
// ----------------------------------------------------------------------------
module euler_trs_matrix_builder import etm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ANGLE_W-1:0]        angle_x,
	input  logic [ANGLE_W-1:0]        angle_y,
	input  logic [ANGLE_W-1:0]        angle_z,
	input  logic signed [SCALE_W-1:0] scale_x,
	input  logic signed [SCALE_W-1:0] scale_y,
	input  logic signed [SCALE_W-1:0] scale_z,
	input  logic [ORDER_W-1:0]        rotation_order,
	output logic                      done,
	output logic signed [OUT_W-1:0]   m00,
	output logic signed [OUT_W-1:0]   m01,
	output logic signed [OUT_W-1:0]   m02,
	output logic signed [OUT_W-1:0]   m10,
	output logic signed [OUT_W-1:0]   m11,
	output logic signed [OUT_W-1:0]   m12,
	output logic signed [OUT_W-1:0]   m20,
	output logic signed [OUT_W-1:0]   m21,
	output logic signed [OUT_W-1:0]   m22,
	output logic                      bad_order
);

	localparam int DLY = TRIG_LAT;   // sine lookup depth, side data waits as long

	// pipeline never stalls, a word can enter every cycle
	assign busy = 1'b0;

	// ---------------------------------------------------------------- trig
	logic                    vld_trig;
	logic signed [ROT_W-1:0] sx, cx, sy, cy, sz, cz;

	etm_cordic u_cordic_x (.clk, .arst_n, .vld_i(start), .angle(angle_x),
		.vld_o(vld_trig), .sin_o(sx), .cos_o(cx));
	etm_cordic u_cordic_y (.clk, .arst_n, .vld_i(start), .angle(angle_y),
		.vld_o(), .sin_o(sy), .cos_o(cy));
	etm_cordic u_cordic_z (.clk, .arst_n, .vld_i(start), .angle(angle_z),
		.vld_o(), .sin_o(sz), .cos_o(cz));

	// side data delay line, kept level with the sine lookup
	logic [ORDER_W-1:0]        ord_d [0:DLY-1];
	logic signed [SCALE_W-1:0] scx_d [0:DLY-1];
	logic signed [SCALE_W-1:0] scy_d [0:DLY-1];
	logic signed [SCALE_W-1:0] scz_d [0:DLY-1];

	always_ff @(posedge clk) begin
		ord_d[0] <= rotation_order;
		scx_d[0] <= scale_x;
		scy_d[0] <= scale_y;
		scz_d[0] <= scale_z;
		for (int i = 0; i < DLY-1; i++) begin
			ord_d[i+1] <= ord_d[i];
			scx_d[i+1] <= scx_d[i];
			scy_d[i+1] <= scy_d[i];
			scz_d[i+1] <= scz_d[i];
		end
	end

	// ---------------------------------------------------------------- per-axis matrices
	mat_t rx, ry, rz;
	logic signed [ENT_W-1:0] one_e, ex_sx, ex_cx, ex_sy, ex_cy, ex_sz, ex_cz;

	always_comb begin
		one_e = ENT_W'(65536);
		ex_sx = ENT_W'(sx); ex_cx = ENT_W'(cx);
		ex_sy = ENT_W'(sy); ex_cy = ENT_W'(cy);
		ex_sz = ENT_W'(sz); ex_cz = ENT_W'(cz);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				rx[i][j] = '0; ry[i][j] = '0; rz[i][j] = '0;
			end
		// rx = [1 0 0; 0 c -s; 0 s c]
		rx[0][0] = one_e;  rx[1][1] = ex_cx; rx[1][2] = -ex_sx;
		rx[2][1] = ex_sx;  rx[2][2] = ex_cx;
		// ry = [c 0 s; 0 1 0; -s 0 c]
		ry[0][0] = ex_cy;  ry[0][2] = ex_sy; ry[1][1] = one_e;
		ry[2][0] = -ex_sy; ry[2][2] = ex_cy;
		// rz = [c -s 0; s c 0; 0 0 1]
		rz[0][0] = ex_cz;  rz[0][1] = -ex_sz; rz[1][0] = ex_sz;
		rz[1][1] = ex_cz;  rz[2][2] = one_e;
	end

	// ---------------------------------------------------------------- order select, stage 1
	mat_t ma, mb, mc;
	mat_t a_s1, b_s1, c_s1, c_s2;
	logic vld_s1, bad_s1, bad_s2, bad_s3;
	logic signed [SCALE_W-1:0] sc_s1 [3];
	logic signed [SCALE_W-1:0] sc_s2 [3];
	logic signed [SCALE_W-1:0] sc_s3 [3];

	always_comb begin
		ma = rz; mb = ry; mc = rx;
		unique case (ord_d[DLY-1])
			ORD_ZYX: begin ma = rz; mb = ry; mc = rx; end
			ORD_ZXY: begin ma = rz; mb = rx; mc = ry; end
			ORD_YXZ: begin ma = ry; mb = rx; mc = rz; end
			ORD_YZX: begin ma = ry; mb = rz; mc = rx; end
			ORD_XYZ: begin ma = rx; mb = ry; mc = rz; end
			ORD_XZY: begin ma = rx; mb = rz; mc = ry; end
			default: begin ma = rz; mb = ry; mc = rx; end   // invalid, zeroed at the end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= vld_trig;
	end

	always_ff @(posedge clk) begin
		a_s1   <= ma;
		b_s1   <= mb;
		c_s1   <= mc;
		bad_s1 <= (ord_d[DLY-1] != ORD_ZYX) && (ord_d[DLY-1] != ORD_ZXY)
			&& (ord_d[DLY-1] != ORD_YXZ) && (ord_d[DLY-1] != ORD_YZX)
			&& (ord_d[DLY-1] != ORD_XYZ) && (ord_d[DLY-1] != ORD_XZY);
		sc_s1[0] <= scx_d[DLY-1];
		sc_s1[1] <= scy_d[DLY-1];
		sc_s1[2] <= scz_d[DLY-1];
	end

	// ---------------------------------------------------------------- left pair, stage 2
	mat_t t_s2;
	logic vld_s2;

	etm_matmul u_mul_left (.clk, .arst_n, .vld_i(vld_s1), .a(a_s1), .b(b_s1),
		.vld_o(vld_s2), .o(t_s2));

	always_ff @(posedge clk) begin
		c_s2   <= c_s1;
		bad_s2 <= bad_s1;
		sc_s2  <= sc_s1;
	end

	// ---------------------------------------------------------------- third factor, stage 3
	mat_t r_s3;
	logic vld_s3;

	etm_matmul u_mul_right (.clk, .arst_n, .vld_i(vld_s2), .a(t_s2), .b(c_s2),
		.vld_o(vld_s3), .o(r_s3));

	always_ff @(posedge clk) begin
		bad_s3 <= bad_s2;
		sc_s3  <= sc_s2;
	end

	// ---------------------------------------------------------------- column scale, output word
	logic signed [ENT_W+SCALE_W-1:0] sp  [3][3];
	logic signed [OUT_W-1:0]         res [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				sp[i][j]  = r_s3[i][j] * sc_s3[j];
				// floor to q16, result always fits 32 bits
				res[i][j] = bad_s3 ? '0 : OUT_W'(sp[i][j] >>> 16);
			end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s3;
	end

	always_ff @(posedge clk) begin
		m00 <= res[0][0]; m01 <= res[0][1]; m02 <= res[0][2];
		m10 <= res[1][0]; m11 <= res[1][1]; m12 <= res[1][2];
		m20 <= res[2][0]; m21 <= res[2][1]; m22 <= res[2][2];
		bad_order <= bad_s3;
	end

endmodule

/* hw/rtl/etm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_checker
// port-level checks on the matrix builder, bound to the top level
// ----------------------------------------------------------------------------
module etm_checker import etm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [ORDER_W-1:0]      rotation_order,
	input logic                    done,
	input logic signed [OUT_W-1:0] m00,
	input logic signed [OUT_W-1:0] m11,
	input logic signed [OUT_W-1:0] m22,
	input logic                    bad_order
);

	// every word out stems from a word taken a fixed time earlier
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without matching start");

	a_bad_follows_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bad_order == ($past(rotation_order[2], LATENCY)
			&& $past(rotation_order[1], LATENCY))))
		else $error("bad_order does not match rotation order");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_order) |-> (m00 == '0 && m11 == '0 && m22 == '0))
		else $error("entries not zero for bad order");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind euler_trs_matrix_builder etm_checker u_etm_checker (
	.clk, .arst_n, .start, .busy, .rotation_order, .done,
	.m00, .m11, .m22, .bad_order
);

/* verif/euler_trs_matrix_builder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_trs_matrix_builder_tb
// feeds euler angles, column scales and rotation orders into the matrix
// builder, predicts every scaled rotation block in fixed point and compares
// each done word entry by entry, with random idle bursts and drain pauses
// ----------------------------------------------------------------------------
module euler_trs_matrix_builder_tb;
	import etm_pkg::*;

	// invalid rotation orders
	localparam logic [ORDER_W-1:0] ORD_BAD_LO = 3'd6;
	localparam logic [ORDER_W-1:0] ORD_BAD_HI = 3'd7;

	// q62 constants for the series sine
	localparam longint unsigned Q62_UNIT  = 64'h1 << 62;
	localparam longint unsigned TURN_STEP = 64'hC90FDAA22168C235 >> 15;
	localparam longint          Q16_UNIT  = 65536;

	localparam int N_RANDOM     = 1880;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		logic [ANGLE_W-1:0]        ax, ay, az;
		logic signed [SCALE_W-1:0] sx, sy, sz;
		logic [ORDER_W-1:0]        ord;
		logic                      drain;   // wait until nothing is in flight
	} xform_t;

	typedef struct packed {
		logic [8:0][OUT_W-1:0] ent;
		logic                  bad;
	} block_t;

	typedef longint rot_t [3][3];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, bad_order;
	logic [ANGLE_W-1:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic signed [SCALE_W-1:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic [ORDER_W-1:0] rotation_order = '0;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	xform_t pending_xforms[$];
	block_t expected_blocks[$];
	int     mismatches = 0;
	logic   taken = 1'b0;
	int     idle_left = 0;
	int     stall_cycles = 0;

	euler_trs_matrix_builder DUT (.*);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------

	// (a * b) >> 62 on unsigned q62 values
	function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// rounded q1.16 sine within the first quadrant, taylor series in horner form
	function automatic longint quadrant_sine(int unsigned r);
		longint unsigned x, x2, s, d;
		x  = longint'(r) * TURN_STEP;
		x2 = q62_mul(x, x);
		s  = Q62_UNIT;
		for (int k = 12; k >= 1; k--) begin
			d = longint'(2 * k) * longint'(2 * k + 1);
			s = Q62_UNIT - q62_mul(x2, s) / d;
		end
		return longint'((q62_mul(x, s) + (64'h1 << 45)) >> 46);
	endfunction

	function automatic longint sine_q16(logic [ANGLE_W-1:0] a);
		longint v;
		v = a[14] ? quadrant_sine(16384 - a[13:0]) : quadrant_sine(a[13:0]);
		return a[15] ? -v : v;
	endfunction

	function automatic rot_t axis_rot(int axis, logic [ANGLE_W-1:0] a);
		rot_t m;
		longint s, c;
		int p, q;
		logic [ANGLE_W-1:0] a_cos;
		a_cos = a + 16'd16384;
		s = sine_q16(a);
		c = sine_q16(a_cos);
		p = (axis + 1) % 3;
		q = (axis + 2) % 3;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = 0;
		m[axis][axis] = Q16_UNIT;
		m[p][p] = c;
		m[q][q] = c;
		m[p][q] = -s;
		m[q][p] = s;
		return m;
	endfunction

	// product of two q16 matrices, each entry floored back to q16
	function automatic rot_t rot_product(rot_t a, rot_t b);
		rot_t o;
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += a[i][k] * b[k][j];
				o[i][j] = acc >>> 16;
			end
		return o;
	endfunction

	function automatic block_t scaled_rotation(xform_t w);
		block_t r;
		rot_t rx, ry, rz, rhs, t, m;
		longint sc [3];
		longint prod;
		r = '0;
		rx = axis_rot(0, w.ax);
		ry = axis_rot(1, w.ay);
		rz = axis_rot(2, w.az);
		// the left pair is multiplied first
		case (w.ord)
			ORD_ZYX: begin t = rot_product(rz, ry); rhs = rx; end
			ORD_ZXY: begin t = rot_product(rz, rx); rhs = ry; end
			ORD_YXZ: begin t = rot_product(ry, rx); rhs = rz; end
			ORD_YZX: begin t = rot_product(ry, rz); rhs = rx; end
			ORD_XYZ: begin t = rot_product(rx, ry); rhs = rz; end
			ORD_XZY: begin t = rot_product(rx, rz); rhs = ry; end
			default: begin
				r.bad = 1'b1;
				return r;
			end
		endcase
		m = rot_product(t, rhs);
		sc[0] = w.sx;
		sc[1] = w.sy;
		sc[2] = w.sz;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				prod = (m[i][j] * sc[j]) >>> 16;
				r.ent[i * 3 + j] = prod[OUT_W-1:0];
			end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// driver: new word at the falling edge once the last one was taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		xform_t w;
		logic go;
		go = 1'b0;
		if (arst_n && (!start || taken)) begin
			if (idle_left > 0)
				idle_left--;
			else if (pending_xforms.size() != 0) begin
				if (pending_xforms[0].drain && expected_blocks.size() != 0)
					go = 1'b0;
				else if (pending_xforms.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
					idle_left = $urandom_range(1, 17) - 1;
				else begin
					w = pending_xforms.pop_front();
					angle_x        <= w.ax;
					angle_y        <= w.ay;
					angle_z        <= w.az;
					scale_x        <= w.sx;
					scale_y        <= w.sy;
					scale_z        <= w.sz;
					rotation_order <= w.ord;
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	// ------------------------------------------------------------------
	// monitor: check done words, record accepted words, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		block_t got, want;
		xform_t w;
		if (arst_n) begin
			if (done) begin
				got.ent = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
				got.bad = bad_order;
				if (expected_blocks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected done word, nothing outstanding");
				end else begin
					want = expected_blocks.pop_front();
					for (int i = 0; i < 9; i++)
						if (got.ent[i] !== want.ent[i]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("m%0d%0d: expected %0d got %0d", i / 3, i % 3,
									$signed(want.ent[i]), $signed(got.ent[i]));
						end
					if (got.bad !== want.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("bad_order: expected %b got %b", want.bad, got.bad);
					end
				end
			end
			taken <= start && !busy;
			if (start && !busy) begin
				w = '{ax: angle_x, ay: angle_y, az: angle_z, sx: scale_x, sy: scale_y,
					sz: scale_z, ord: rotation_order, drain: 1'b0};
				expected_blocks.push_back(scaled_rotation(w));
			end
			// watchdog on cycles where nothing moves while work remains
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else if (pending_xforms.size() != 0 || expected_blocks.size() != 0 || start) begin
				if (stall_cycles >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end else
					stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 3))
			0: return 24'($signed($urandom_range(0, 262144)) - 131072);
			1: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_xform(logic [ANGLE_W-1:0] ax, ay, az,
			logic signed [SCALE_W-1:0] sx, sy, sz, logic [ORDER_W-1:0] ord, logic drain);
		pending_xforms.push_back('{ax: ax, ay: ay, az: az, sx: sx, sy: sy, sz: sz,
			ord: ord, drain: drain});
	endtask

	initial begin
		logic [ORDER_W-1:0] ord;
		// directed: identity, every order, quadrant edges, scale extremes, invalid orders
		add_xform(16'd0, 16'd0, 16'd0, 24'sh010000, 24'sh010000, 24'sh010000, ORD_ZYX, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_ZYX, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_ZXY, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_YXZ, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_YZX, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_XYZ, 1'b0);
		add_xform(16'd5000, 16'd21000, 16'd40000, 24'sh010000, 24'sh020000,
			-24'sh008000, ORD_XZY, 1'b0);
		add_xform(16'd16384, 16'd32768, 16'd49152, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
			ORD_XYZ, 1'b0);
		add_xform(16'hFFFF, 16'hFFFF, 16'hFFFF, -24'sh800000, -24'sh800000, -24'sh800000,
			ORD_ZYX, 1'b0);
		add_xform(16'd1, 16'd16383, 16'd32767, 24'sh000000, 24'sh000001, -24'sh000001,
			ORD_YZX, 1'b0);
		add_xform(16'd8192, 16'd8192, 16'd8192, 24'sh7FFFFF, -24'sh800000, 24'sh010000,
			ORD_ZXY, 1'b0);
		add_xform(16'd49153, 16'd32769, 16'd16385, -24'sh000001, 24'sh7FFFFF, -24'sh800000,
			ORD_XZY, 1'b0);
		add_xform(16'd1234, 16'd4321, 16'd9999, 24'sh010000, 24'sh010000, 24'sh010000,
			ORD_BAD_LO, 1'b0);
		add_xform(16'hFFFF, 16'd0, 16'hAAAA, 24'sh7FFFFF, -24'sh800000, 24'sh555555,
			ORD_BAD_HI, 1'b0);
		// sender pauses here until every block has come back
		add_xform(16'd24576, 16'd40960, 16'd57344, 24'sh018000, -24'sh00C000, 24'sh030000,
			ORD_YXZ, 1'b1);
		for (int n = 0; n < N_RANDOM; n++) begin
			ord = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			add_xform(pick_angle(), pick_angle(), pick_angle(), pick_scale(), pick_scale(),
				pick_scale(), ord, n == N_RANDOM / 2);
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// wait for all words to go in and all blocks to come out
		do
			@(posedge clk);
		while (pending_xforms.size() != 0 || start || expected_blocks.size() != 0);
		repeat (LATENCY + 8) @(posedge clk);

		if (mismatches == 0 && expected_blocks.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
